@@ design/fgsd_pkg.sv @@
// shared types and constants of the flight/ground state detector
// no dependencies; every other file of the block imports this package
`default_nettype none

package fgsd_pkg;

    localparam int FGSD_SPEED_BITS = 20;   // default width of the speed field
    localparam int CFG_SPEED_W     = 20;   // width of the speed threshold registers
    localparam int DOP_W           = 16;
    localparam int RATIO_W         = 8;
    localparam int TIME_W          = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [DOP_W-1:0]       DOP_UNITY_RST     = 16'd100;
    localparam logic [CFG_SPEED_W-1:0] FLIGHT_SPEED_RST  = 20'd10000;
    localparam logic [CFG_SPEED_W-1:0] GROUND_SPEED_RST  = 20'd2000;
    localparam logic [CFG_SPEED_W-1:0] LANDING_SPEED_RST = 20'd5000;
    localparam logic [CFG_SPEED_W-1:0] TAXI_SPEED_RST    = 20'd3000;
    localparam logic [RATIO_W-1:0]     JERK_RATIO_RST    = 8'd3;
    localparam logic [TIME_W-1:0]      LANDING_HOLD_RST  = 32'd10000;

    typedef enum logic [1:0] {
        FS_UNKNOWN  = 2'd0,
        FS_GROUND   = 2'd1,
        FS_AIRBORNE = 2'd2
    } flight_state_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DOP_UNITY     = 3'd0,
        CFG_FLIGHT_SPEED  = 3'd1,
        CFG_GROUND_SPEED  = 3'd2,
        CFG_LANDING_SPEED = 3'd3,
        CFG_TAXI_SPEED    = 3'd4,
        CFG_JERK_RATIO    = 3'd5,
        CFG_LANDING_HOLD  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;        // capture the sample beat
        logic mul;         // register the products
        logic div_start;   // launch the derating division
        logic commit;      // update state and load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic slot_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/fgsd_if.sv @@
// channel interfaces of the flight/ground state detector: sample, result, config
// depends on fgsd_pkg
`default_nettype none

interface fgsd_in_if
    import fgsd_pkg::*;
#(
    parameter int SPEED_BITS = FGSD_SPEED_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  gnss_fix;
    logic [SPEED_BITS-1:0] speed;
    logic [DOP_W-1:0]      hdop;
    logic [TIME_W-1:0]     now_ms;

    modport source (output valid, gnss_fix, speed, hdop, now_ms, input ready);
    modport sink   (input valid, gnss_fix, speed, hdop, now_ms, output ready);
endinterface

interface fgsd_out_if
    import fgsd_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] flight_state;
    logic       rolling;

    modport source (output valid, flight_state, rolling, input ready);
    modport sink   (input valid, flight_state, rolling, output ready);
endinterface

interface fgsd_cfg_if
    import fgsd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ design/flight_ground_state_detector.sv @@
// Flight/ground state detector. Each sample beat (fix flag, speed in mm/s, hdop x100,
// millisecond time) yields exactly one result beat with the flight state (0 unknown,
// 1 on ground, 2 airborne) and the taxi rolling flag. Items are processed one at a time:
// a sample is captured, its products are registered and, when hdop derating is needed,
// the rounded derating division runs, the divider producing one quotient bit per cycle,
// before the result is committed. A finished result sits in an output register, so the
// next sample is accepted while it waits. The config port is always ready; write it
// only while the block is idle. Writes to addresses past the last register are ignored.
// depends on fgsd_pkg, fgsd_if, fgsd_ctrl, fgsd_dp
`default_nettype none

module flight_ground_state_detector
    import fgsd_pkg::*;
#(
    parameter int SPEED_BITS = FGSD_SPEED_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fgsd_in_if.sink   sample,
    fgsd_out_if.source result,
    fgsd_cfg_if.sink  cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    fgsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fgsd_dp #(
        .SPEED_BITS (SPEED_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg.addr),
        .cfg_data     (cfg.data),
        .gnss_fix     (sample.gnss_fix),
        .speed        (sample.speed),
        .hdop         (sample.hdop),
        .now_ms       (sample.now_ms),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .flight_state (result.flight_state),
        .rolling      (result.rolling)
    );

    // one item in flight: no second beat right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample accepted while an item is in flight");

    // the divider is never running while a new sample can be taken
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !status.div_busy)
        else $error("divider busy while idle");

    // a launched division is busy on the next cycle
    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy)
        else $error("division did not start");

    // a commit always produces a valid result beat
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result.valid)
        else $error("committed result not presented");

endmodule

`default_nettype wire

@@ design/fgsd_div.sv @@
// iterative restoring divider for the rounded hdop derating, one quotient bit per cycle
// depends on fgsd_pkg
`default_nettype none

module fgsd_div
    import fgsd_pkg::*;
#(
    parameter int SPEED_BITS = FGSD_SPEED_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [SPEED_BITS+DOP_W:0]       num,
    input  wire logic [DOP_W-1:0]                den,
    output logic                                 busy,
    output logic [SPEED_BITS:0]                  quot
);

    localparam int Q_W   = SPEED_BITS + 1;
    localparam int NUM_W = SPEED_BITS + DOP_W + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DOP_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DOP_W:0]   trial;
    logic [DOP_W:0]   diff;
    logic             ge;

    // quotient is known to fit Q_W bits, so the upper numerator bits start below den
    always_comb
    begin
        trial = {rem_reg, quo_reg[Q_W-1]};
        ge    = trial >= {1'b0, den};
        diff  = trial - {1'b0, den};
        if (start)
        begin
            rem_next = num[NUM_W-1:Q_W];
            quo_next = num[Q_W-1:0];
            cnt_next = CNT_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[DOP_W-1:0] : trial[DOP_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            rem_next = rem_reg;
            quo_next = quo_reg;
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = quo_reg;

endmodule

`default_nettype wire

@@ design/fgsd_dp.sv @@
// datapath: config registers, sample capture, products, divider, detector state, result register
// depends on fgsd_pkg and fgsd_div
`default_nettype none

module fgsd_dp
    import fgsd_pkg::*;
#(
    parameter int SPEED_BITS = FGSD_SPEED_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  gnss_fix,
    input  wire logic [SPEED_BITS-1:0] speed,
    input  wire logic [DOP_W-1:0]      hdop,
    input  wire logic [TIME_W-1:0]     now_ms,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 flight_state,
    output logic                       rolling
);

    localparam int Q_W   = SPEED_BITS + 1;
    localparam int NUM_W = SPEED_BITS + DOP_W + 1;
    localparam int PRD_W = SPEED_BITS + DOP_W;
    localparam int JMP_W = SPEED_BITS + RATIO_W;
    localparam int CMP_W = (SPEED_BITS > CFG_SPEED_W) ? SPEED_BITS : CFG_SPEED_W;
    localparam int EFF_W = (Q_W > CFG_SPEED_W) ? Q_W : CFG_SPEED_W;

    // configuration
    logic [DOP_W-1:0]       dop_unity_reg;
    logic [CFG_SPEED_W-1:0] flight_speed_reg;
    logic [CFG_SPEED_W-1:0] ground_speed_reg;
    logic [CFG_SPEED_W-1:0] landing_speed_reg;
    logic [CFG_SPEED_W-1:0] taxi_speed_reg;
    logic [RATIO_W-1:0]     jerk_ratio_reg;
    logic [TIME_W-1:0]      landing_hold_reg;

    // captured sample and products
    logic                  fix_reg;
    logic [SPEED_BITS-1:0] spd_reg;
    logic [DOP_W-1:0]      hdop_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [PRD_W-1:0]      prod_reg;
    logic [JMP_W-1:0]      jmp_after_reg;
    logic [JMP_W-1:0]      jmp_before_reg;

    // detector state
    flight_state_t         cur_state_reg, cur_state_next;
    logic                  armed_reg, armed_next;
    logic [SPEED_BITS-1:0] prev_speed_reg, prev_speed_next;
    logic                  slow_active_reg, slow_active_next;
    logic [TIME_W-1:0]     slow_start_reg, slow_start_next;
    logic                  rolling_flag_reg, rolling_flag_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    flight_state_t         out_state_reg, out_state_next;
    logic                  out_rolling_reg;

    logic                  derate;
    logic [NUM_W-1:0]      div_num;
    logic [Q_W-1:0]        quot;
    logic                  div_busy;
    logic [Q_W-1:0]        eff;
    logic                  evidence;
    logic                  jump;
    logic [CMP_W-1:0]      spd_cmp;
    logic                  slow_clear;
    logic [TIME_W-1:0]     elapsed;
    logic                  held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dop_unity_reg     <= DOP_UNITY_RST;
            flight_speed_reg  <= FLIGHT_SPEED_RST;
            ground_speed_reg  <= GROUND_SPEED_RST;
            landing_speed_reg <= LANDING_SPEED_RST;
            taxi_speed_reg    <= TAXI_SPEED_RST;
            jerk_ratio_reg    <= JERK_RATIO_RST;
            landing_hold_reg  <= LANDING_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DOP_UNITY:     dop_unity_reg     <= cfg_data[DOP_W-1:0];
                CFG_FLIGHT_SPEED:  flight_speed_reg  <= cfg_data[CFG_SPEED_W-1:0];
                CFG_GROUND_SPEED:  ground_speed_reg  <= cfg_data[CFG_SPEED_W-1:0];
                CFG_LANDING_SPEED: landing_speed_reg <= cfg_data[CFG_SPEED_W-1:0];
                CFG_TAXI_SPEED:    taxi_speed_reg    <= cfg_data[CFG_SPEED_W-1:0];
                CFG_JERK_RATIO:    jerk_ratio_reg    <= cfg_data[RATIO_W-1:0];
                CFG_LANDING_HOLD:  landing_hold_reg  <= cfg_data[TIME_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fix_reg  <= gnss_fix;
            spd_reg  <= speed;
            hdop_reg <= hdop;
            now_reg  <= now_ms;
        end
        if (cmd.mul)
        begin
            prod_reg       <= PRD_W'(spd_reg) * PRD_W'(dop_unity_reg);
            jmp_after_reg  <= JMP_W'(spd_reg) * JMP_W'(jerk_ratio_reg);
            jmp_before_reg <= JMP_W'(prev_speed_reg) * JMP_W'(jerk_ratio_reg);
        end
    end

    // rounded division: (speed * unity + hdop / 2) / hdop
    assign derate  = hdop_reg > dop_unity_reg;
    assign div_num = NUM_W'(prod_reg) + NUM_W'(hdop_reg >> 1);

    fgsd_div #(
        .SPEED_BITS (SPEED_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (hdop_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_comb
    begin
        spd_cmp  = CMP_W'(spd_reg);
        eff      = derate ? quot : Q_W'(spd_reg);
        evidence = EFF_W'(eff) >= EFF_W'(flight_speed_reg);
        jump     = (JMP_W'(spd_reg) > jmp_before_reg) || (JMP_W'(prev_speed_reg) > jmp_after_reg);

        // slow taxi timer
        slow_clear       = !fix_reg || (spd_cmp >= CMP_W'(landing_speed_reg));
        slow_active_next = !slow_clear;
        slow_start_next  = (!slow_clear && !slow_active_reg) ? now_reg : slow_start_reg;
        elapsed          = now_reg - slow_start_next;
        held             = slow_active_next && (elapsed >= landing_hold_reg);

        rolling_flag_next = rolling_flag_reg;
        cur_state_next    = cur_state_reg;
        armed_next        = fix_reg;
        prev_speed_next   = fix_reg ? spd_reg : prev_speed_reg;

        if (fix_reg)
        begin
            if (spd_cmp >= CMP_W'(taxi_speed_reg))
                rolling_flag_next = 1'b1;
            else if (spd_cmp < CMP_W'(ground_speed_reg))
                rolling_flag_next = 1'b0;

            unique case (cur_state_reg)
                FS_UNKNOWN:
                    cur_state_next = evidence ? FS_AIRBORNE : FS_GROUND;
                FS_AIRBORNE:
                    if ((spd_cmp < CMP_W'(ground_speed_reg)) || held)
                        cur_state_next = FS_GROUND;
                FS_GROUND:
                    if (evidence && !(armed_reg && jump))
                        cur_state_next = FS_AIRBORNE;
                default:
                    cur_state_next = cur_state_reg;
            endcase
        end

        out_state_next = fix_reg ? cur_state_next : FS_UNKNOWN;

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg    <= FS_UNKNOWN;
            armed_reg        <= 1'b0;
            prev_speed_reg   <= '0;
            slow_active_reg  <= 1'b0;
            slow_start_reg   <= '0;
            rolling_flag_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit)
            begin
                cur_state_reg    <= cur_state_next;
                armed_reg        <= armed_next;
                prev_speed_reg   <= prev_speed_next;
                slow_active_reg  <= slow_active_next;
                slow_start_reg   <= slow_start_next;
                rolling_flag_reg <= rolling_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_state_reg   <= out_state_next;
            out_rolling_reg <= rolling_flag_next;
        end
    end

    assign status.need_div  = fix_reg && (cur_state_reg != FS_AIRBORNE) && derate;
    assign status.div_busy  = div_busy;
    assign status.slot_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign flight_state = out_state_reg;
    assign rolling      = out_rolling_reg;

endmodule

`default_nettype wire

@@ design/fgsd_ctrl.sv @@
// controller state machine sequencing capture, multiply, divide and commit
// depends on fgsd_pkg
`default_nettype none

module fgsd_ctrl
    import fgsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = status.need_div ? ST_DSTART : ST_COMMIT;
            ST_DSTART:
                state_next = ST_DWAIT;
            ST_DWAIT:
                if (!status.div_busy)
                    state_next = ST_COMMIT;
            ST_COMMIT:
                if (status.slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = state_reg == ST_IDLE;
        cmd.load      = (state_reg == ST_IDLE) && in_valid;
        cmd.mul       = state_reg == ST_MUL;
        cmd.div_start = state_reg == ST_DSTART;
        // hold the finished item until the result register can take it
        cmd.commit    = (state_reg == ST_COMMIT) && status.slot_free;
    end

endmodule

`default_nettype wire
